[hdl/assert_macros.svh]
// Assertion helpers used by the estimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hdl/wve_pkg.sv]
`default_nettype none
package wve_pkg;

  localparam int RATE_W      = 10;
  localparam int WIN_W       = 5;
  localparam int POS_W       = 24;
  localparam int RES_W       = 32;
  localparam int DATA_W      = 33;  // sign-extended history value
  localparam int DIFF_W      = 34;
  localparam int PROD_W      = 45;
  localparam int MAG_W       = 43;  // |difference * rate| always fits
  localparam int ITER_W      = 6;

  localparam logic [RATE_W-1:0] RATE_RESET   = 10'd30;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 5'd10;

  localparam logic REG_RATE   = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ORIGIN,
    ST_DROP_RD,
    ST_DROP_CHK,
    ST_PREP,
    ST_SCAN,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_POST,
    ST_OUT
  } state_t;

  // Apply sign to a quotient magnitude and clamp to 32 bits.
  function automatic logic [RES_W-1:0] sat32(input logic [MAG_W-1:0] mag, input logic neg);
    logic [MAG_W-1:0] t;
    t = ~mag + MAG_W'(1);
    if (neg) begin
      if (mag > MAG_W'(33'h080000000)) return 32'h80000000;
      return t[RES_W-1:0];
    end
    if (mag > MAG_W'(32'h7fffffff)) return 32'h7fffffff;
    return mag[RES_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/windowed_velocity_estimator.sv]
// Windowed finite-difference velocity and acceleration estimator.
// Input stream (s_axis): one transaction per 3-axis position sample in mm.
// Output stream (m_axis): one transaction per input with velocity,
// acceleration and a dropout flag. Config port: cfg_we writes cfg_data into
// register cfg_index (0 = rate_hz, 1 = window) on the clock edge; write only
// while the block is idle.
// Throughput: one sample at a time. Each of the two passes runs setup,
// reference read, multiply, 43 divide steps and write-back; the reference
// read skips all-zero history entries, one per cycle. The result then goes to
// the output register and the block returns to idle for the next sample. A
// frozen sample cuts a pass to setup and write-back, short history drops the
// dropout compare, and the origin sample skips both passes.
// Histories live in two synchronous RAMs (position and velocity).
// Reset: rst clears pointers, counters and the registers to 30 Hz, window 10;
// history contents are left as is and are only read once written.
// Stall: a finished result waits in the output register; the block still
// takes the next sample and holds its result until m_axis_tready frees the
// register.
`default_nettype none
`include "assert_macros.svh"
module windowed_velocity_estimator #(
  parameter int HIST_DEPTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [199:0] m_axis_tdata,   // vel_x..z, acc_x..z, dropout, zero fill
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [9:0]   cfg_data
);

  localparam int AW = $clog2(HIST_DEPTH);
  localparam int CW = $clog2(HIST_DEPTH + 1);
  localparam logic [CW-1:0] FREEZE_MAX = CW'(HIST_DEPTH - 2);
  localparam logic [CW-1:0] DEPTH_CNT  = CW'(HIST_DEPTH);
  localparam int PW = 3 * wve_pkg::POS_W;
  localparam int VW = 3 * wve_pkg::RES_W;

  wve_pkg::state_t state, state_next;

  logic [wve_pkg::RATE_W-1:0] rate;
  logic [wve_pkg::WIN_W-1:0]  win;
  logic [AW-1:0] wptr, newest;
  logic [CW-1:0] scnt, fcnt, k, divr;
  logic          lost, phase;   // phase: 0 position pass, 1 velocity pass
  logic signed [wve_pkg::POS_W-1:0] npos [3];
  logic signed [wve_pkg::RES_W-1:0] vel [3];
  logic signed [wve_pkg::RES_W-1:0] acc [3];
  logic signed [wve_pkg::DATA_W-1:0] refv [3];
  logic [wve_pkg::MAG_W-1:0] mag [3];
  logic [CW-1:0]             rem [3];
  logic                      neg [3];
  logic [wve_pkg::ITER_W-1:0] iter;

  logic [PW-1:0] pos_rdata;
  logic [VW-1:0] vel_rdata, vel_wdata;
  logic          vel_we, in_fire;
  logic [AW-1:0] raddr;
  logic [CW-1:0] k_sel, w_ext, kp1;
  logic          normal, rd_zero;
  logic signed [wve_pkg::DATA_W-1:0] rd_v [3];
  logic signed [wve_pkg::DATA_W-1:0] new_v [3];
  logic [wve_pkg::RES_W-1:0] res [3];

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == wve_pkg::ST_IDLE);
  assign w_ext  = (win == '0) ? CW'(1) : CW'(win);
  assign normal = ({1'b0, scnt} > ({1'b0, w_ext} + (CW + 1)'(1)));
  assign kp1    = k + CW'(1);

  // slot of the entry k_sel back from newest
  function automatic logic [AW-1:0] back_slot(input logic [AW-1:0] base, input logic [CW-1:0] kk);
    logic [AW:0] t;
    t = {1'b0, base} - (AW + 1)'(kk);
    if (t[AW]) t = t + (AW + 1)'(HIST_DEPTH);
    return t[AW-1:0];
  endfunction

  always_comb begin
    case (state)
      wve_pkg::ST_DROP_RD: k_sel = fcnt + CW'(1);
      wve_pkg::ST_PREP:    k_sel = normal ? w_ext : (scnt - CW'(1));
      wve_pkg::ST_SCAN:    k_sel = kp1;
      default:             k_sel = CW'(1);
    endcase
    raddr = back_slot(newest, k_sel);
  end

  generate
    for (genvar i = 0; i < 3; i++) begin : g_lane
      assign rd_v[i] = phase
        ? wve_pkg::DATA_W'(signed'(vel_rdata[i*wve_pkg::RES_W +: wve_pkg::RES_W]))
        : wve_pkg::DATA_W'(signed'(pos_rdata[i*wve_pkg::POS_W +: wve_pkg::POS_W]));
      assign new_v[i] = phase ? wve_pkg::DATA_W'(vel[i]) : wve_pkg::DATA_W'(npos[i]);
      assign res[i]   = wve_pkg::sat32(mag[i], neg[i]);
    end
  endgenerate

  assign rd_zero = phase ? (vel_rdata == '0) : (pos_rdata == '0);

  wve_ram #(.WIDTH(PW), .DEPTH(HIST_DEPTH)) u_pos_ram (
    .clk(clk), .we(in_fire), .waddr(wptr), .wdata(s_axis_tdata),
    .raddr(raddr), .rdata(pos_rdata)
  );

  wve_ram #(.WIDTH(VW), .DEPTH(HIST_DEPTH)) u_vel_ram (
    .clk(clk), .we(vel_we), .waddr(newest), .wdata(vel_wdata),
    .raddr(raddr), .rdata(vel_rdata)
  );

  always_comb begin
    vel_we     = 1'b0;
    vel_wdata  = {res[2], res[1], res[0]};
    state_next = state;
    case (state)
      wve_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = (scnt == '0) ? wve_pkg::ST_ORIGIN : wve_pkg::ST_DROP_RD;
        end
      end
      wve_pkg::ST_ORIGIN: begin
        vel_we     = 1'b1;
        vel_wdata  = '0;
        state_next = wve_pkg::ST_OUT;
      end
      wve_pkg::ST_DROP_RD: begin
        state_next = (scnt < w_ext) ? wve_pkg::ST_PREP : wve_pkg::ST_DROP_CHK;
      end
      wve_pkg::ST_DROP_CHK: state_next = wve_pkg::ST_PREP;
      wve_pkg::ST_PREP: begin
        if (lost) begin
          state_next = wve_pkg::ST_POST;
        end else begin
          state_next = normal ? wve_pkg::ST_SCAN : wve_pkg::ST_LOAD;
        end
      end
      wve_pkg::ST_SCAN: begin
        if (!rd_zero) begin
          state_next = wve_pkg::ST_MUL;
        end else if (kp1 >= scnt - CW'(1)) begin
          state_next = wve_pkg::ST_LOAD;
        end
      end
      wve_pkg::ST_LOAD: state_next = wve_pkg::ST_MUL;
      wve_pkg::ST_MUL:  state_next = wve_pkg::ST_DIV;
      wve_pkg::ST_DIV: begin
        if (iter == wve_pkg::ITER_W'(wve_pkg::MAG_W - 1)) state_next = wve_pkg::ST_POST;
      end
      wve_pkg::ST_POST: begin
        if (!phase) begin
          vel_we     = 1'b1;
          state_next = wve_pkg::ST_PREP;
        end else begin
          state_next = wve_pkg::ST_OUT;
        end
      end
      wve_pkg::ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = wve_pkg::ST_IDLE;
      end
      default: state_next = wve_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wve_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate          <= wve_pkg::RATE_RESET;
      win           <= wve_pkg::WINDOW_RESET;
      wptr          <= '0;
      scnt          <= '0;
      fcnt          <= '0;
      lost          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wve_pkg::REG_RATE:   rate <= cfg_data;
          wve_pkg::REG_WINDOW: win  <= cfg_data[wve_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
      // drop valid once taken, unless a new result loads in the same cycle
      if (m_axis_tvalid && m_axis_tready && state != wve_pkg::ST_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        wve_pkg::ST_IDLE: begin
          if (in_fire) begin
            wptr <= (wptr == AW'(HIST_DEPTH - 1)) ? '0 : wptr + AW'(1);
            if (scnt == '0) begin
              scnt <= CW'(1);
              lost <= 1'b0;
              fcnt <= '0;
            end else if (scnt < DEPTH_CNT) begin
              scnt <= scnt + CW'(1);
            end
          end
        end
        wve_pkg::ST_DROP_RD: begin
          if (scnt < w_ext) begin
            lost <= 1'b0;
            fcnt <= '0;
          end
        end
        wve_pkg::ST_DROP_CHK: begin
          // hold dropout while the sample matches the last differing one
          if (pos_rdata == {npos[2], npos[1], npos[0]}) begin
            lost <= 1'b1;
            if (fcnt < FREEZE_MAX) fcnt <= fcnt + CW'(1);
          end else begin
            lost <= 1'b0;
            fcnt <= '0;
          end
        end
        wve_pkg::ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) m_axis_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      wve_pkg::ST_IDLE: begin
        newest  <= wptr;
        phase   <= 1'b0;
        npos[0] <= s_axis_tdata[23:0];
        npos[1] <= s_axis_tdata[47:24];
        npos[2] <= s_axis_tdata[71:48];
      end
      wve_pkg::ST_ORIGIN: begin
        for (int i = 0; i < 3; i++) begin
          vel[i] <= '0;
          acc[i] <= '0;
        end
      end
      wve_pkg::ST_PREP: begin
        k    <= w_ext;
        divr <= normal ? w_ext : scnt;
        for (int i = 0; i < 3; i++) begin
          mag[i] <= '0;
          neg[i] <= 1'b0;
        end
      end
      wve_pkg::ST_SCAN: begin
        if (!rd_zero) begin
          for (int i = 0; i < 3; i++) refv[i] <= rd_v[i];
          divr <= k;
        end else begin
          k    <= kp1;
          divr <= kp1;
        end
      end
      wve_pkg::ST_LOAD: begin
        for (int i = 0; i < 3; i++) refv[i] <= rd_v[i];
      end
      wve_pkg::ST_MUL: begin
        for (int i = 0; i < 3; i++) begin
          logic signed [wve_pkg::DIFF_W-1:0] d;
          logic signed [wve_pkg::PROD_W-1:0] p;
          d      = wve_pkg::DIFF_W'(new_v[i]) - wve_pkg::DIFF_W'(refv[i]);
          p      = wve_pkg::PROD_W'(d) * wve_pkg::PROD_W'(signed'({1'b0, rate}));
          neg[i] <= p[wve_pkg::PROD_W-1];
          mag[i] <= p[wve_pkg::PROD_W-1] ? wve_pkg::MAG_W'(-p) : wve_pkg::MAG_W'(p);
          rem[i] <= '0;
        end
        iter <= '0;
      end
      wve_pkg::ST_DIV: begin
        // one quotient bit per lane per cycle
        for (int i = 0; i < 3; i++) begin
          logic [CW:0] sh;
          sh = {rem[i], mag[i][wve_pkg::MAG_W-1]};
          if (sh >= {1'b0, divr}) begin
            rem[i] <= CW'(sh - {1'b0, divr});
            mag[i] <= {mag[i][wve_pkg::MAG_W-2:0], 1'b1};
          end else begin
            rem[i] <= sh[CW-1:0];
            mag[i] <= {mag[i][wve_pkg::MAG_W-2:0], 1'b0};
          end
        end
        iter <= iter + wve_pkg::ITER_W'(1);
      end
      wve_pkg::ST_POST: begin
        for (int i = 0; i < 3; i++) begin
          if (!phase) vel[i] <= res[i];
          else        acc[i] <= res[i];
        end
        phase <= 1'b1;
      end
      wve_pkg::ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {7'b0, lost, acc[2], acc[1], acc[0], vel[2], vel[1], vel[0]};
        end
      end
      default: ;
    endcase
  end

  `ASSERT_CLK(a_freeze_bound, fcnt <= FREEZE_MAX, "freeze count past oldest entry")
  `ASSERT_CLK(a_count_bound, scnt <= DEPTH_CNT, "sample count past history depth")
  `ASSERT_CLK(a_div_nonzero, (state == wve_pkg::ST_DIV) |-> (divr != '0), "zero divisor")
  `ASSERT_CLK(a_accept_busy, in_fire |=> (state != wve_pkg::ST_IDLE), "accept left block idle")

endmodule
`default_nettype wire

[hdl/wve_ram.sv]
`default_nettype none
module wve_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
// Testbench for windowed_velocity_estimator.
// Samples go in on the s_axis stream and each one is also run through a
// behavioral estimator kept in this file. That estimator tracks its own copy
// of the position and velocity histories, the freeze counter and the two
// registers. The expected velocity, acceleration and dropout flag go into a
// FIFO. Every m_axis transaction is compared field by field with the oldest
// entry. The run moves through directed cases (origin, field extremes,
// short history, dropout, zero skip, rate and window extremes), then random
// trajectories under several sender/receiver idle mixes, and then a long
// receiver hold-off that fills the block.
module tb;

  localparam int DEPTH      = 64;
  localparam int FRZ_MAX    = DEPTH - 2;
  localparam int DRAIN_WAIT = 300;
  localparam int WDOG_LIMIT = 6000;   // cycles with no transaction on either stream

  // lowest field last so that vel_x lands in bits 31:0
  typedef struct packed {
    logic        dropout;
    logic [31:0] acc_z, acc_y, acc_x;
    logic [31:0] vel_z, vel_y, vel_x;
  } motion_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;    // pos_x, pos_y, pos_z
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;         // vel_x..z, acc_x..z, dropout, zero fill
  logic         cfg_we = 1'b0;
  logic         cfg_index = wve_pkg::REG_RATE;
  logic [9:0]   cfg_data = '0;

  windowed_velocity_estimator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Estimator state, mirrored from the block's behavior.
  int      pos_h [3][DEPTH];
  int      vel_h [3][DEPTH];
  int      wr_ptr, n_samples, frz_cnt;
  bit      lost;
  int      rate_reg = 30;
  int      win_reg  = 10;

  motion_t expected_q[$];
  int      errors;
  int      n_sent, n_recv, n_drop, n_sat;
  int      send_idle_pct, recv_stall_pct;
  bit      hold_req;
  int      hold_left;
  int      quiet_cycles;
  logic [23:0] cur_x, cur_y, cur_z;

  function automatic int slot_back(int newest, int k);
    return (newest + DEPTH - (k % DEPTH)) % DEPTH;
  endfunction

  function automatic int hist_val(bit from_vel, int axis, int slot);
    return from_vel ? vel_h[axis][slot] : pos_h[axis][slot];
  endfunction

  function automatic bit hist_zero(bit from_vel, int slot);
    return hist_val(from_vel, 0, slot) == 0 && hist_val(from_vel, 1, slot) == 0 &&
           hist_val(from_vel, 2, slot) == 0;
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) begin
      n_sat++;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      n_sat++;
      return 32'h80000000;
    end
    return int'(v);
  endfunction

  // Windowed difference over one history; skips all-zero reference entries.
  function automatic void diff_hist(bit from_vel, int newest, int w, output int res[3]);
    int     k, dvsr, s;
    longint d;
    if (lost) begin
      res = '{0, 0, 0};
      return;
    end
    if (n_samples > w + 1) begin
      k = w;
      if (hist_zero(from_vel, slot_back(newest, k))) begin
        k = w + 1;
        while (k < n_samples - 1 && hist_zero(from_vel, slot_back(newest, k)))
          k++;
      end
      dvsr = k;
    end else begin
      k    = n_samples - 1;
      dvsr = n_samples;
    end
    s = slot_back(newest, k);
    for (int a = 0; a < 3; a++) begin
      d = (longint'(hist_val(from_vel, a, newest)) - hist_val(from_vel, a, s)) * rate_reg;
      res[a] = clamp32(d / dvsr);
    end
  endfunction

  function automatic motion_t estimate_motion(logic [23:0] px, logic [23:0] py,
                                              logic [23:0] pz);
    int      newest, w, r;
    int      vel[3], acc[3];
    motion_t m;
    newest = wr_ptr;
    w      = (win_reg == 0) ? 1 : win_reg;
    vel    = '{0, 0, 0};
    acc    = '{0, 0, 0};
    pos_h[0][newest] = int'($signed(px));
    pos_h[1][newest] = int'($signed(py));
    pos_h[2][newest] = int'($signed(pz));
    wr_ptr = (newest + 1) % DEPTH;
    if (n_samples == 0) begin
      n_samples = 1;
      lost      = 1'b0;
      frz_cnt   = 0;
    end else begin
      if (n_samples < DEPTH) n_samples++;
      if (n_samples < w) begin
        lost    = 1'b0;
        frz_cnt = 0;
      end else begin
        r = slot_back(newest, 1 + frz_cnt);
        if (pos_h[0][r] == pos_h[0][newest] && pos_h[1][r] == pos_h[1][newest] &&
            pos_h[2][r] == pos_h[2][newest]) begin
          lost = 1'b1;
          if (frz_cnt < FRZ_MAX) frz_cnt++;
        end else begin
          lost    = 1'b0;
          frz_cnt = 0;
        end
      end
      diff_hist(1'b0, newest, w, vel);
    end
    for (int a = 0; a < 3; a++) vel_h[a][newest] = vel[a];
    if (n_samples > 1) diff_hist(1'b1, newest, w, acc);
    m.vel_x = vel[0]; m.vel_y = vel[1]; m.vel_z = vel[2];
    m.acc_x = acc[0]; m.acc_y = acc[1]; m.acc_z = acc[2];
    m.dropout = lost;
    return m;
  endfunction

  // Send one sample; the valid stays high into the next call unless it idles.
  task automatic send_sample(logic [23:0] px, logic [23:0] py, logic [23:0] pz);
    motion_t m;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px};
    do @(posedge clk); while (!s_axis_tready);
    m = estimate_motion(px, py, pz);
    expected_q.insert(expected_q.size(), m);
    n_sent++;
    if (m.dropout) n_drop++;
    cur_x = px; cur_y = py; cur_z = pz;
  endtask

  // Drop valid, let all results come back, then let the block settle.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[9:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == wve_pkg::REG_RATE) rate_reg = value & 10'h3ff;
    else win_reg = value & 5'h1f;
  endtask

  // Random trajectory step: mostly small moves, some freezes, zeros and jumps.
  task automatic send_trajectory(int count);
    int roll;
    logic [23:0] nx, ny, nz;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        nx = cur_x; ny = cur_y; nz = cur_z;
      end else if (roll < 13) begin
        nx = '0; ny = '0; nz = '0;
      end else if (roll < 20) begin
        nx = 24'($urandom); ny = 24'($urandom); nz = 24'($urandom);
      end else begin
        nx = cur_x + 24'($signed($urandom_range(400)) - 200);
        ny = cur_y + 24'($signed($urandom_range(400)) - 200);
        nz = cur_z + 24'($signed($urandom_range(60)) - 30);
      end
      send_sample(nx, ny, nz);
    end
  endtask

  task automatic test_origin_and_extremes;
    send_sample(24'h000100, 24'hffff00, 24'h000010);   // origin
    send_sample(24'h7fffff, 24'h800000, 24'h7fffff);
    send_sample(24'h800000, 24'h7fffff, 24'h800000);
    send_sample(24'h000000, 24'h000000, 24'h000000);
    send_sample(24'hffffff, 24'h000001, 24'h555555);
    send_sample(24'haaaaaa, 24'h555555, 24'haaaaaa);
  endtask

  task automatic test_dropout;
    write_reg(wve_pkg::REG_WINDOW, 3);
    send_sample(24'h001000, 24'h002000, 24'h003000);
    for (int i = 0; i < 5; i++) send_sample(24'h001000, 24'h002000, 24'h003000);
    send_sample(24'h001234, 24'h002000, 24'h003000);
    send_sample(24'h001000, 24'h002000, 24'h003000);   // equal to an older differing sample
  endtask

  task automatic test_zero_skip;
    write_reg(wve_pkg::REG_WINDOW, 2);
    send_sample(24'h000400, 24'h000500, 24'h000600);
    for (int i = 0; i < 4; i++) send_sample('0, '0, '0);
    send_sample(24'h000900, 24'hfff000, 24'h000001);
    send_sample(24'h000a00, 24'hffe000, 24'h000002);
    send_sample(24'h000b00, 24'hffd000, 24'h000003);
  endtask

  task automatic test_register_extremes;
    write_reg(wve_pkg::REG_RATE, 1000);
    write_reg(wve_pkg::REG_WINDOW, 1);
    send_sample(24'h800000, 24'h7fffff, 24'h800000);
    send_sample(24'h7fffff, 24'h800000, 24'h7fffff);
    write_reg(wve_pkg::REG_WINDOW, 0);   // acts as one
    send_sample(24'h800000, 24'h000000, 24'h123456);
    write_reg(wve_pkg::REG_RATE, 0);
    send_sample(24'h7fffff, 24'h7fffff, 24'h7fffff);
    write_reg(wve_pkg::REG_RATE, 1);
    write_reg(wve_pkg::REG_WINDOW, 31);
    send_sample(24'h000001, 24'h000002, 24'h000003);
    send_sample(24'h000005, 24'h000007, 24'h000009);
  endtask

  task automatic test_random_mixes;
    int settings[4][2] = '{'{30, 10}, '{1000, 31}, '{1, 1}, '{517, 6}};
    int idle_mix[4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{36, 36}};
    for (int p = 0; p < 4; p++) begin
      write_reg(wve_pkg::REG_RATE, settings[p][0]);
      write_reg(wve_pkg::REG_WINDOW, settings[p][1]);
      send_idle_pct  = idle_mix[p][0];
      recv_stall_pct = idle_mix[p][1];
      send_trajectory(90);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_trajectory(15);
    end
  endtask

  task automatic test_backpressure;
    write_reg(wve_pkg::REG_RATE, $urandom_range(1000));
    write_reg(wve_pkg::REG_WINDOW, $urandom_range(31));
    hold_req = 1'b1;
    send_trajectory(25);
  endtask

  // Receiver: check each result, then pick the ready for the next edge.
  always @(posedge clk) begin
    motion_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = motion_t'(m_axis_tdata[192:0]);
      n_recv++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.vel_x !== want.vel_x) begin
          $error("vel_x exp %0d got %0d", $signed(want.vel_x), $signed(got.vel_x)); errors++;
        end
        if (got.vel_y !== want.vel_y) begin
          $error("vel_y exp %0d got %0d", $signed(want.vel_y), $signed(got.vel_y)); errors++;
        end
        if (got.vel_z !== want.vel_z) begin
          $error("vel_z exp %0d got %0d", $signed(want.vel_z), $signed(got.vel_z)); errors++;
        end
        if (got.acc_x !== want.acc_x) begin
          $error("acc_x exp %0d got %0d", $signed(want.acc_x), $signed(got.acc_x)); errors++;
        end
        if (got.acc_y !== want.acc_y) begin
          $error("acc_y exp %0d got %0d", $signed(want.acc_y), $signed(got.acc_y)); errors++;
        end
        if (got.acc_z !== want.acc_z) begin
          $error("acc_z exp %0d got %0d", $signed(want.acc_z), $signed(got.acc_z)); errors++;
        end
        if (got.dropout !== want.dropout) begin
          $error("dropout exp %0d got %0d", want.dropout, got.dropout); errors++;
        end
      end
    end
    // Long hold-off: keep ready low while the sender keeps offering samples.
    if (hold_req && hold_left == 0) begin
      hold_req  = 1'b0;
      hold_left = 900;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles in which neither stream moves a transaction.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WDOG_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    wr_ptr = 0; n_samples = 0; frz_cnt = 0; lost = 1'b0;
    errors = 0; n_sent = 0; n_recv = 0; n_drop = 0; n_sat = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_req = 1'b0; hold_left = 0; quiet_cycles = 0;
    cur_x = '0; cur_y = '0; cur_z = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_origin_and_extremes();
    test_dropout();
    test_zero_skip();
    test_register_extremes();
    test_random_mixes();
    test_backpressure();
    drain();

    $display("tb: %0d samples sent, %0d results checked, %0d with dropout,", n_sent, n_recv,
             n_drop);
    $display("tb: %0d saturated terms, rate 0..1000 and window 0..31, long output hold-off",
             n_sat);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
